// ===== rtl/cbts_pkg.sv =====
// shared types and constants of the can bit timing search
package cbts_pkg;

    localparam int CLK_W  = 27;
    localparam int RATE_W = 20;
    localparam int TQ_W   = 6;
    localparam int DIV_W  = 26;
    localparam int SEG_W  = 5;
    localparam int IDX_W  = 3;
    localparam int CNT_W  = 5;

    // one quotient bit per step
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(CLK_W - 1);

    localparam logic [IDX_W-1:0] REG_CLOCK_HZ    = 3'd0;
    localparam logic [IDX_W-1:0] REG_QUANTA_MIN  = 3'd1;
    localparam logic [IDX_W-1:0] REG_QUANTA_MAX  = 3'd2;
    localparam logic [IDX_W-1:0] REG_SEG_ONE_MIN = 3'd3;
    localparam logic [IDX_W-1:0] REG_SEG_ONE_MAX = 3'd4;
    localparam logic [IDX_W-1:0] REG_SEG_TWO_MIN = 3'd5;
    localparam logic [IDX_W-1:0] REG_SEG_TWO_MAX = 3'd6;

    localparam logic [CLK_W-1:0] RST_CLOCK_HZ    = 27'd24000000;
    localparam logic [TQ_W-1:0]  RST_QUANTA_MIN  = 6'd8;
    localparam logic [TQ_W-1:0]  RST_QUANTA_MAX  = 6'd25;
    localparam logic [TQ_W-1:0]  RST_SEG_ONE_MIN = 6'd4;
    localparam logic [TQ_W-1:0]  RST_SEG_ONE_MAX = 6'd16;
    localparam logic [TQ_W-1:0]  RST_SEG_TWO_MIN = 6'd2;
    localparam logic [TQ_W-1:0]  RST_SEG_TWO_MAX = 6'd8;

    typedef struct packed {
        logic [CLK_W-1:0] clock_hz;
        logic [TQ_W-1:0]  quanta_min;
        logic [TQ_W-1:0]  quanta_max;
        logic [TQ_W-1:0]  seg_one_min;
        logic [TQ_W-1:0]  seg_one_max;
        logic [TQ_W-1:0]  seg_two_min;
        logic [TQ_W-1:0]  seg_two_max;
    } t_cfg;

    typedef struct packed {
        logic start;    // capture bitrate, load largest count, clear result
        logic prod;     // form divisor, load dividend
        logic step;     // one restoring division step
        logic accept;   // latch result of current count
        logic dec;      // next smaller count
    } t_cmd;

    typedef struct packed {
        logic rate_zero;
        logic tq_ok;
        logic hit;
    } t_sts;

endpackage

// ===== rtl/can_bit_timing_search_unit.sv =====
// top level of the can bit timing search: config registers, controller, datapath
//
// usage: write the seven timing registers through the config channel
// (i_cfg_valid/o_cfg_ready, index 0..6, data in i_cfg_data; ready is always
// high, index 7 is ignored). for registers to take effect for the next search
// only, the user must not write them while o_busy is high; the block does not
// enforce this. start a search by raising i_start with the bitrate word on
// i_bitrate; the word is taken at a clock edge where i_start is high and
// o_busy is low. the block then tries quanta counts from quanta_max down to
// quanta_min; for each count it forms count*bitrate, runs the one-bit-per-step
// restoring divider, then does the remainder and segment checks. o_done
// pulses for one cycle when a count hits, when none of the tried counts fits,
// or for a zero bitrate. with reset limits at most 18 counts are tried.
// the result ports hold their value until the next start. o_done cannot be
// held off by the receiver; the result must be taken in its strobe cycle.
// one search runs at a time. synchronous active-low reset returns the
// registers to their reset values and the controller to idle.
module can_bit_timing_search_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [cbts_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [cbts_pkg::CLK_W-1:0]  i_cfg_data,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic [cbts_pkg::RATE_W-1:0] i_bitrate,
    output logic                        o_done,
    output logic                        o_timing_valid,
    output logic [cbts_pkg::CLK_W-1:0]  o_prescaler,
    output logic [cbts_pkg::SEG_W-1:0]  o_seg_one,
    output logic [cbts_pkg::SEG_W-1:0]  o_seg_two
);

    cbts_pkg::t_cfg w_cfg;
    cbts_pkg::t_cmd w_cmd;
    cbts_pkg::t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    cbts_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid & o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    cbts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (o_busy),
        .o_done  (o_done)
    );

    cbts_dp u_dp (
        .i_clk          (i_clk),
        .i_cfg          (w_cfg),
        .i_cmd          (w_cmd),
        .i_bitrate      (i_bitrate),
        .o_sts          (w_sts),
        .o_timing_valid (o_timing_valid),
        .o_prescaler    (o_prescaler),
        .o_seg_one      (o_seg_one),
        .o_seg_two      (o_seg_two)
    );

endmodule

// ===== rtl/cbts_cfg.sv =====
// configuration register file of the can bit timing search
module cbts_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_we,
    input  logic [cbts_pkg::IDX_W-1:0]  i_index,
    input  logic [cbts_pkg::CLK_W-1:0]  i_data,
    output cbts_pkg::t_cfg              o_cfg
);

    cbts_pkg::t_cfg r_cfg;
    cbts_pkg::t_cfg n_cfg;
    logic [cbts_pkg::TQ_W-1:0] w_v6;

    assign w_v6 = i_data[cbts_pkg::TQ_W-1:0];

    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            unique case (i_index)
                cbts_pkg::REG_CLOCK_HZ:    n_cfg.clock_hz    = i_data;
                cbts_pkg::REG_QUANTA_MIN:  n_cfg.quanta_min  = w_v6;
                cbts_pkg::REG_QUANTA_MAX:  n_cfg.quanta_max  = w_v6;
                cbts_pkg::REG_SEG_ONE_MIN: n_cfg.seg_one_min = w_v6;
                cbts_pkg::REG_SEG_ONE_MAX: n_cfg.seg_one_max = w_v6;
                cbts_pkg::REG_SEG_TWO_MIN: n_cfg.seg_two_min = w_v6;
                cbts_pkg::REG_SEG_TWO_MAX: n_cfg.seg_two_max = w_v6;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clock_hz    <= cbts_pkg::RST_CLOCK_HZ;
            r_cfg.quanta_min  <= cbts_pkg::RST_QUANTA_MIN;
            r_cfg.quanta_max  <= cbts_pkg::RST_QUANTA_MAX;
            r_cfg.seg_one_min <= cbts_pkg::RST_SEG_ONE_MIN;
            r_cfg.seg_one_max <= cbts_pkg::RST_SEG_ONE_MAX;
            r_cfg.seg_two_min <= cbts_pkg::RST_SEG_TWO_MIN;
            r_cfg.seg_two_max <= cbts_pkg::RST_SEG_TWO_MAX;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/cbts_dp.sv =====
// datapath: divisor product, restoring divider, segment split and limit checks
module cbts_dp (
    input  logic                        i_clk,
    input  cbts_pkg::t_cfg              i_cfg,
    input  cbts_pkg::t_cmd              i_cmd,
    input  logic [cbts_pkg::RATE_W-1:0] i_bitrate,
    output cbts_pkg::t_sts              o_sts,
    output logic                        o_timing_valid,
    output logic [cbts_pkg::CLK_W-1:0]  o_prescaler,
    output logic [cbts_pkg::SEG_W-1:0]  o_seg_one,
    output logic [cbts_pkg::SEG_W-1:0]  o_seg_two
);

    logic [cbts_pkg::RATE_W-1:0] r_rate;
    logic [cbts_pkg::TQ_W-1:0]   r_tq;
    logic [cbts_pkg::DIV_W-1:0]  r_div;
    logic [cbts_pkg::DIV_W-1:0]  r_rem;
    logic [cbts_pkg::CLK_W-1:0]  r_quo;
    logic                        r_valid;
    logic [cbts_pkg::CLK_W-1:0]  r_presc;
    logic [cbts_pkg::SEG_W-1:0]  r_seg1;
    logic [cbts_pkg::SEG_W-1:0]  r_seg2;

    logic [cbts_pkg::DIV_W-1:0]  w_prod;
    logic [cbts_pkg::CLK_W-1:0]  w_trial;
    logic [cbts_pkg::CLK_W-1:0]  w_diff;
    logic                        w_ge;
    logic [32:0]                 w_r100;
    logic [7:0]                  w_tq3;
    logic [cbts_pkg::TQ_W-1:0]   w_three;
    logic [cbts_pkg::TQ_W-1:0]   w_s1;
    logic [cbts_pkg::TQ_W-1:0]   w_s2;
    logic                        w_seg_ok;

    assign w_prod = {20'd0, r_tq} * {6'd0, r_rate};

    // remainder stays below the divisor, so the shifted trial fits
    assign w_trial = {r_rem, r_quo[cbts_pkg::CLK_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};

    // 100 * r as 64r + 32r + 4r
    assign w_r100 = {1'b0, r_rem, 6'd0} + {2'd0, r_rem, 5'd0} + {5'd0, r_rem, 2'd0};

    assign w_tq3   = {2'd0, r_tq} + {1'b0, r_tq, 1'b0};
    assign w_three = w_tq3[7:2];
    assign w_s1    = w_three - 6'd1;
    assign w_s2    = r_tq - w_three;

    assign w_seg_ok = (w_three != 6'd0) && !w_s1[5] && !w_s2[5]
                   && (w_s1 >= i_cfg.seg_one_min) && (w_s1 <= i_cfg.seg_one_max)
                   && (w_s2 >= i_cfg.seg_two_min) && (w_s2 <= i_cfg.seg_two_max);

    assign o_sts.rate_zero = (r_rate == '0);
    assign o_sts.tq_ok     = (r_tq != '0) && (r_tq >= i_cfg.quanta_min);
    assign o_sts.hit       = (r_quo != '0) && (w_r100 < {7'd0, r_div}) && w_seg_ok;

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rate  <= i_bitrate;
            r_tq    <= i_cfg.quanta_max;
            r_valid <= 1'b0;
            r_presc <= '0;
            r_seg1  <= '0;
            r_seg2  <= '0;
        end
        if (i_cmd.prod) begin
            r_div <= w_prod;
            r_rem <= '0;
            r_quo <= i_cfg.clock_hz;
        end
        if (i_cmd.step) begin
            r_rem <= w_ge ? w_diff[cbts_pkg::DIV_W-1:0] : w_trial[cbts_pkg::DIV_W-1:0];
            r_quo <= {r_quo[cbts_pkg::CLK_W-2:0], w_ge};
        end
        if (i_cmd.accept) begin
            r_valid <= 1'b1;
            r_presc <= r_quo;
            r_seg1  <= w_s1[cbts_pkg::SEG_W-1:0];
            r_seg2  <= w_s2[cbts_pkg::SEG_W-1:0];
        end
        if (i_cmd.dec) begin
            r_tq <= r_tq - 6'd1;
        end
    end

    assign o_timing_valid = r_valid;
    assign o_prescaler    = r_presc;
    assign o_seg_one      = r_seg1;
    assign o_seg_two      = r_seg2;

endmodule

// ===== rtl/cbts_ctrl.sv =====
// controller: sequences the search over quanta counts and the division steps
module cbts_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  cbts_pkg::t_sts  i_sts,
    output cbts_pkg::t_cmd  o_cmd,
    output logic            o_busy,
    output logic            o_done
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_TQ   = 5'b00010,
        S_DIV  = 5'b00100,
        S_TEST = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state                    r_state;
    t_state                    n_state;
    logic [cbts_pkg::CNT_W-1:0] r_cnt;
    logic [cbts_pkg::CNT_W-1:0] n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_TQ;
                end
            end
            S_TQ: begin
                if (i_sts.rate_zero || !i_sts.tq_ok) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.prod = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + 5'd1;
                if (r_cnt == cbts_pkg::DIV_LAST) begin
                    n_state = S_TEST;
                end
            end
            S_TEST: begin
                if (i_sts.hit) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.dec = 1'b1;
                    n_state   = S_TQ;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done && !o_busy)
        else $error("result strobe longer than one cycle");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (r_state == S_TQ))
        else $error("accepted word did not start a search");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TQ && n_state == S_DIV) |=> (r_cnt == '0))
        else $error("division step counter not cleared");

    a_test_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TEST) |-> $past(r_state == S_DIV && r_cnt == cbts_pkg::DIV_LAST))
        else $error("candidate tested before division finished");

endmodule
